/* design/cpvg_pkg.sv */
// Package for the circle polygon vertex generator.
// Holds the request and vertex word types, the sideband type and the sine series constants.
`default_nettype none
package cpvg_pkg;

  // Request word
  typedef struct packed {
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic        [13:0] circle_radius;
    logic        [5:0]  segment_count;
  } req_t;

  // Vertex word
  typedef struct packed {
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic               stroke_start;
    logic               stroke_end;
  } vtx_t;

  // Sideband that travels with each vertex through the pipeline
  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic        [13:0] radius;
    logic               first;
    logic               last;
  } meta_t;

  // One trig lane: Q30 angle, its square, Horner term, dividend and scratch product
  typedef struct packed {
    logic [30:0] x;
    logic [31:0] x2;
    logic [30:0] t;
    logic [31:0] p;
    logic [62:0] acc;
    logic        neg;
  } lane_t;

  localparam int          NumTerms   = 6;
  localparam logic [30:0] Q30One     = 31'd1073741824;
  localparam logic [30:0] Q30HalfPi  = 31'd1686629713;

  // Horner divisors and floor(2^32 / divisor)
  localparam logic [7:0]  SIN_DIV   [NumTerms] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [29:0] SIN_RECIP [NumTerms] = '{30'd27531841, 30'd39045157, 30'd59652323,
                                                   30'd102261126, 30'd214748364, 30'd715827882};

  // Clamp an 18-bit signed sum to 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/circle_polygon_vertex_generator.sv */
// Circle polygon vertex generator: a request of n segments (n clamped to 3..MAX_SEGMENTS) gives n+1 vertex words.
// Vertices leave through a 25-stage pipeline fed by the vertex sequencer, which issues one
// vertex per cycle while the output is not stalled and holds one request at a time.
// Reset (asynchronous, active low) clears the sequencer and all pipeline valid bits.
// Depends on cpvg_pkg.
`default_nettype none
module circle_polygon_vertex_generator import cpvg_pkg::*; #(
  parameter int MAX_SEGMENTS   = 63,
  parameter int PHASE_BITS     = 16,
  parameter int TRIG_FRAC_BITS = 15
) (
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic in_valid_i,
  output logic       in_ready_o,
  input  wire  req_t in_data_i,
  output logic       out_valid_o,
  input  wire  logic out_ready_i,
  output vtx_t       out_data_o
);

  localparam int PB    = PHASE_BITS;
  localparam int QB    = PHASE_BITS - 2;
  localparam int TF    = TRIG_FRAC_BITS;
  localparam int NH    = 3 * NumTerms;
  localparam int NS    = NH + 7;
  localparam int PW    = TF + 16;
  localparam logic [PB-1:0] Quarter = PB'(1) << QB;

  // Phase increment table, floor(2^PB / n) for every count, with counts below 3 using n = 3
  logic [PB-1:0] inc_tab [64];
  for (genvar g = 0; g < 64; g++) begin : g_inc
    localparam int Div = (g < 3) ? 3 : g;
    localparam logic [PB-1:0] IncVal = PB'((64'd1 << PB) / Div);
    assign inc_tab[g] = IncVal;
  end

  // Pipeline advance: move all stages when the output register is free or taken
  logic en;
  logic [NS-1:0] vld_q;
  meta_t meta_q [NS];
  assign en = !vld_q[NS-1] || out_ready_i;

  // ---------------- Sequencer ----------------
  logic          busy_q;
  logic [5:0]    k_q, n_q;
  logic [PB-1:0] acc_q, inc_q;
  logic signed [15:0] hcx_q, hcy_q;
  logic [13:0]   hr_q;
  logic [5:0]    n_clamp;
  logic [PB-1:0] ph_issue;
  logic [PB-1:0] ph0_q;

  assign in_ready_o = !busy_q;

  always_comb begin
    if (in_data_i.segment_count < 6'd3) begin
      n_clamp = 6'd3;
    end else if (in_data_i.segment_count > 6'(MAX_SEGMENTS)) begin
      n_clamp = 6'(MAX_SEGMENTS);
    end else begin
      n_clamp = in_data_i.segment_count;
    end
  end

  assign ph_issue = (k_q == n_q) ? '0 : acc_q;

  // Take a request, then step through its vertices
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
      n_q    <= '0;
      acc_q  <= '0;
      inc_q  <= '0;
    end else if (in_valid_i && !busy_q) begin
      busy_q <= 1'b1;
      k_q    <= '0;
      n_q    <= n_clamp;
      acc_q  <= '0;
      inc_q  <= inc_tab[n_clamp];
    end else if (busy_q && en) begin
      k_q   <= k_q + 6'd1;
      acc_q <= acc_q + inc_q;
      if (k_q == n_q) begin
        busy_q <= 1'b0;
        acc_q  <= '0;
      end
    end
  end

  // Hold the centre and radius of the request
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !busy_q) begin
      hcx_q <= in_data_i.center_x;
      hcy_q <= in_data_i.center_y;
      hr_q  <= in_data_i.circle_radius;
    end
  end

  // ---------------- Valid and sideband shift ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], busy_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ph0_q     <= ph_issue;
      meta_q[0] <= '{cx: hcx_q, cy: hcy_q, radius: hr_q,
                     first: (k_q == 6'd0), last: (k_q == n_q)};
      for (int i = 1; i < NS; i++) begin
        meta_q[i] <= meta_q[i-1];
      end
    end
  end

  // ---------------- Trig lanes: 0 is sine, 1 is cosine ----------------
  logic [30:0] ang_q [2];
  logic        neg1_q [2];
  lane_t       hz_q [2][NH+1];
  logic [30:0] m_q [2];
  logic        negm_q [2];
  logic signed [TF:0]   s_q [2];
  logic signed [PW-1:0] prod_q [2];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [PB-1:0]  ph;
    logic [QB:0]    off;
    logic [QB+31:0] ang_full;
    logic [61:0]    sq_full;
    logic [61:0]    m_full;
    logic [31:0]    m_rnd;
    logic [TF+1:0]  m_sh;
    logic [TF:0]    m_sat;

    // Fold the phase into the first quadrant and scale to Q30 radians
    assign ph  = (l == 0) ? ph0_q : ph0_q + Quarter;
    assign off = ph[PB-2] ? (QB+1)'(Quarter) - {1'b0, ph[QB-1:0]}
                          : {1'b0, ph[QB-1:0]};
    assign ang_full = (QB+32)'(off) * (QB+32)'(Q30HalfPi);

    always_ff @(posedge clk_i) begin
      if (en) begin
        ang_q[l]  <= ang_full[QB+30:QB];
        neg1_q[l] <= ph[PB-1];
      end
    end

    // Square of the angle
    assign sq_full = 62'(ang_q[l]) * 62'(ang_q[l]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        hz_q[l][0] <= '{x: ang_q[l], x2: sq_full[61:30], t: Q30One, p: '0, acc: '0,
                       neg: neg1_q[l]};
      end
    end

    // Horner steps: product, reciprocal multiply, quotient correction
    for (genvar s = 0; s < NH; s++) begin : g_h
      localparam int Step = s / 3;
      localparam int Kind = s % 3;
      lane_t       nx;
      logic [29:0] q0;
      logic [39:0] rem;
      logic [30:0] q;

      assign q0  = hz_q[l][s].acc[61:32];
      assign rem = 40'(hz_q[l][s].p) - 40'(q0) * 40'(SIN_DIV[Step]);
      assign q   = 31'(q0) + ((rem >= 40'(SIN_DIV[Step])) ? 31'd1 : 31'd0);

      always_comb begin
        nx = hz_q[l][s];
        case (Kind)
          0: nx.acc = 63'(hz_q[l][s].x2) * 63'(hz_q[l][s].t);
          1: begin
            nx.p   = hz_q[l][s].acc[61:30];
            nx.acc = 63'(hz_q[l][s].acc[61:30]) * 63'(SIN_RECIP[Step]);
          end
          default: nx.t = Q30One - q;
        endcase
      end

      always_ff @(posedge clk_i) begin
        if (en) begin
          hz_q[l][s+1] <= nx;
        end
      end
    end

    // Sine magnitude, rounding, saturation and sign
    assign m_full = 62'(hz_q[l][NH].x) * 62'(hz_q[l][NH].t);
    assign m_rnd  = 32'(m_q[l]) + (32'd1 << (29 - TF));
    assign m_sh   = m_rnd[31:30-TF];
    assign m_sat  = (m_sh > (TF+2)'((1 << TF) - 1)) ? (TF+1)'((1 << TF) - 1) : m_sh[TF:0];

    always_ff @(posedge clk_i) begin
      if (en) begin
        m_q[l]    <= m_full[60:30];
        negm_q[l] <= hz_q[l][NH].neg;
        s_q[l]    <= negm_q[l] ? -$signed(m_sat) : $signed(m_sat);
        prod_q[l] <= PW'($signed({1'b0, meta_q[NH+4].radius})) * PW'(s_q[l]);
      end
    end
  end

  // ---------------- Output: round, offset from the centre, saturate ----------------
  logic signed [PW-1:0] dx_r, dy_r;
  logic signed [17:0]   sum_x, sum_y;
  vtx_t                 out_q;

  assign dx_r  = (prod_q[0] + PW'(1 << (TF - 1))) >>> TF;
  assign dy_r  = (prod_q[1] + PW'(1 << (TF - 1))) >>> TF;
  assign sum_x = 18'(meta_q[NS-2].cx) + 18'(dx_r);
  assign sum_y = 18'(meta_q[NS-2].cy) - 18'(dy_r);

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= '{vertex_x: sat16(sum_x), vertex_y: sat16(sum_y),
                 stroke_start: meta_q[NS-2].first, stroke_end: meta_q[NS-2].last};
    end
  end

  assign out_valid_o = vld_q[NS-1];
  assign out_data_o  = out_q;

  // ---------------- Assertions ----------------
  // A vertex never both opens and closes a stroke
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.stroke_start && out_data_o.stroke_end))
    else $error("vertex flagged as both start and end");

  // The sequencer goes idle only after issuing the closing vertex
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> (vld_q[0] && meta_q[0].last))
    else $error("sequencer left busy without the closing vertex");

  // The opening vertex is issued at phase zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[0] && meta_q[0].first) |-> (ph0_q == '0))
    else $error("first vertex issued at a non-zero phase");

endmodule
`default_nettype wire
